// ===== hdl/mg3_pkg.sv =====
// ----------------------------------------------------------------------------
// mg3_pkg
// Shared constants and types for the 3x3 morphological gradient block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mg3_pkg;

  localparam int unsigned MAX_WIDTH = 4096;
  localparam int unsigned ADDR_W    = $clog2(MAX_WIDTH);
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned WIDTH_W   = 13;
  localparam int unsigned HEIGHT_W  = 16;
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned COL_W     = 12;
  localparam int unsigned FILL_W    = ADDR_W + 1;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned WIN_N     = 9;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = CFG_IDX_W'(1);

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic              emit;
    logic              last;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } meta_t;

endpackage : mg3_pkg

`default_nettype wire

// ===== hdl/morph_gradient_3x3.sv =====
// ----------------------------------------------------------------------------
// morph_gradient_3x3
// Streaming 3x3 grayscale external gradient (dilation minus centre).
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the input channel (in_valid_i, in_stall_o,
// pixel_value_i). For every interior centre the block returns the 3x3 maximum
// minus the centre value with the centre row and column and a last-of-frame
// flag on the output channel (out_valid_o, out_stall_i). Border pixels give
// no item. Frame width and height are set through the configuration port,
// which is always ready.
// One pixel is taken every clock while in_stall_o is low. A result passes the
// line store read register, then the window register, and the nine-way
// maximum of the window then feeds the result register. The line stores are
// one-port-read, one-port-write arrays with a registered read; a fill mark
// makes columns never written read as zero. Reset clears counters, the fill
// mark and all valid flags; width returns to 640 and height to 480. When the
// receiver stalls the output register holds and the pipeline fills;
// in_stall_o rises once no stage can move.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module morph_gradient_3x3
  import mg3_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [PIX_W-1:0]      pixel_value_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [PIX_W-1:0]      gradient_value_o,
  output      logic [ROW_W-1:0]      center_row_o,
  output      logic [COL_W-1:0]      center_col_o,
  output      logic                  frame_last_o,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0]  cfg_data_i
);

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  logic [ROW_W-1:0]    row_q, row_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [FILL_W-1:0]   fill_q;

  logic                col_wrap;
  logic [ROW_W-1:0]    row_a, r0, row_b;
  logic [COL_W-1:0]    c0;
  logic [WIDTH_W-1:0]  col_inc;
  meta_t               meta0;
  logic                accept;

  logic                s1_valid_q;
  pix_t                s1_px_q;
  meta_t               s1_meta_q;
  logic [ADDR_W-1:0]   s1_addr_q;
  logic                s1_zero_q;
  logic                s1_fwd_q;
  pix_t                s1_fwd_up_q, s1_fwd_mid_q;
  pix_t                up_rd_q, mid_rd_q;
  pix_t                top1, mid1;
  logic                s1_adv;
  logic                fwd_d;

  pix_t                upper_mem  [MAX_WIDTH];
  pix_t                middle_mem [MAX_WIDTH];

  pix_t                win_q [WIN_N];
  logic                s2_valid_q;
  meta_t               s2_meta_q;
  logic                s2_adv;
  pix_t                win_max;

  logic                out_valid_q;
  pix_t                grad_q;
  logic [ROW_W-1:0]    orow_q;
  logic [COL_W-1:0]    ocol_q;
  logic                olast_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IDX_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_IDX_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else if (width_q < WIDTH_MIN) begin
      w_eff = WIDTH_MIN;
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q < HEIGHT_MIN) ? HEIGHT_MIN : height_q;
  end

  // position of the incoming pixel and of the next one
  always_comb begin
    col_wrap = {1'b0, col_q} >= w_eff;
    row_a    = col_wrap ? row_q + ROW_W'(1) : row_q;
    r0       = (row_a >= h_eff) ? '0 : row_a;
    c0       = col_wrap ? '0 : col_q;
    col_inc  = {1'b0, c0} + WIDTH_W'(1);
    row_b    = r0 + ROW_W'(1);
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_b >= h_eff) ? '0 : row_b;
    end else begin
      col_d = col_inc[COL_W-1:0];
      row_d = r0;
    end
    meta0.emit = (r0 >= ROW_W'(2)) && (c0 >= COL_W'(2));
    meta0.last = (r0 == h_eff - HEIGHT_W'(1)) && ({1'b0, c0} == w_eff - WIDTH_W'(1));
    meta0.row  = r0 - ROW_W'(1);
    meta0.col  = c0 - COL_W'(1);
  end

  assign s2_adv     = s2_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_adv     = s1_valid_q && (!s2_valid_q || s2_adv);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign fwd_d      = s1_adv && (c0 == s1_addr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      fill_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        row_q      <= row_d;
        col_q      <= col_d;
        s1_valid_q <= 1'b1;
        if ({1'b0, c0} >= fill_q) begin
          fill_q <= {1'b0, c0} + FILL_W'(1);
        end
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q      <= pixel_value_i;
      s1_meta_q    <= meta0;
      s1_addr_q    <= c0;
      s1_zero_q    <= {1'b0, c0} >= fill_q;
      s1_fwd_q     <= fwd_d;
      s1_fwd_up_q  <= mid1;
      s1_fwd_mid_q <= s1_px_q;
    end
  end

  // line stores: read on accept, write back when the item leaves stage one
  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_rd_q  <= upper_mem[c0];
      mid_rd_q <= middle_mem[c0];
    end
    if (s1_adv) begin
      upper_mem[s1_addr_q]  <= mid1;
      middle_mem[s1_addr_q] <= s1_px_q;
    end
  end

  always_comb begin
    if (s1_fwd_q) begin
      top1 = s1_fwd_up_q;
      mid1 = s1_fwd_mid_q;
    end else if (s1_zero_q) begin
      top1 = '0;
      mid1 = '0;
    end else begin
      top1 = up_rd_q;
      mid1 = mid_rd_q;
    end
  end

  // window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_q <= s1_meta_q.emit;
    end else if (s2_adv) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_meta_q <= s1_meta_q;
      win_q[0]  <= win_q[1];
      win_q[1]  <= win_q[2];
      win_q[2]  <= top1;
      win_q[3]  <= win_q[4];
      win_q[4]  <= win_q[5];
      win_q[5]  <= mid1;
      win_q[6]  <= win_q[7];
      win_q[7]  <= win_q[8];
      win_q[8]  <= s1_px_q;
    end
  end

  always_comb begin
    win_max = win_q[0];
    for (int k = 1; k < WIN_N; k++) begin
      if (win_q[k] > win_max) begin
        win_max = win_q[k];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      grad_q  <= win_max - win_q[4];
      orow_q  <= s2_meta_q.row;
      ocol_q  <= s2_meta_q.col;
      olast_q <= s2_meta_q.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign gradient_value_o = grad_q;
  assign center_row_o     = orow_q;
  assign center_col_o     = ocol_q;
  assign frame_last_o     = olast_q;

endmodule : morph_gradient_3x3

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming 3x3 morphological gradient block.
// ----------------------------------------------------------------------------
// Pixels are pushed in raster order through the valid/stall input channel.
// Each accepted pixel is run through a bit-accurate software copy of the line
// stores, window and frame counters, and any interior result it produces is
// queued. Every item leaving the block is checked field by field against the
// oldest queued result. Named tests cover the reset geometry, saturated and
// blank windows, clamped and masked frame sizes, ignored register indexes,
// the widest and tallest frames, resizing mid-frame and random frames. Both
// channels stall and idle in random bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mg3_pkg::*;

  localparam int unsigned CLK_HALF       = 5;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned PIPE_SETTLE    = 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS   = 300;
  localparam int unsigned MAX_REPORTS    = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RSVD2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RSVD3 = CFG_IDX_W'(3);

  typedef struct packed {
    logic [PIX_W-1:0] grad;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } gradient_t;

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] value;
  } reg_write_t;

  typedef enum int unsigned {TONE_FULL, TONE_BINARY, TONE_BAND} tone_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [PIX_W-1:0]     pixel_value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [PIX_W-1:0]     gradient_value_o;
  logic [ROW_W-1:0]     center_row_o;
  logic [COL_W-1:0]     center_col_o;
  logic                 frame_last_o;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i    = '0;

  // software copy of the block
  logic [WIDTH_W-1:0]  width_reg  = WIDTH_RESET;
  logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
  logic [PIX_W-1:0]    upper_line  [MAX_WIDTH];
  logic [PIX_W-1:0]    middle_line [MAX_WIDTH];
  logic [PIX_W-1:0]    window      [WIN_N];
  int unsigned         row_cnt = 0;
  int unsigned         col_cnt = 0;

  gradient_t  pending_gradients[$];
  reg_write_t reg_writes_q[$];
  gradient_t  exp_res;
  gradient_t  got_res;

  bit          src_gaps_en   = 1'b1;
  bit          sink_stall_en = 1'b1;
  int unsigned stall_left    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned n_pixels      = 0;
  int unsigned n_results     = 0;
  int unsigned n_frame_ends  = 0;
  int unsigned n_reg_writes  = 0;
  int unsigned n_errors      = 0;

  morph_gradient_3x3 DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pixel_value_i    (pixel_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .gradient_value_o (gradient_value_o),
    .center_row_o     (center_row_o),
    .center_col_o     (center_col_o),
    .frame_last_o     (frame_last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic int unsigned frame_width();
    int unsigned w;
    w = (width_reg > WIDTH_MAX) ? MAX_WIDTH : int'(width_reg);
    return (w < WIDTH_MIN) ? int'(WIDTH_MIN) : w;
  endfunction

  function automatic int unsigned frame_height();
    return (height_reg < HEIGHT_MIN) ? int'(HEIGHT_MIN) : int'(height_reg);
  endfunction

  function automatic void predict_gradient(input logic [PIX_W-1:0] pix);
    int unsigned w, h, r, c;
    logic [PIX_W-1:0] top, mid, peak;
    w = frame_width();
    h = frame_height();
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    r = row_cnt;
    c = col_cnt;
    top = upper_line[c];
    mid = middle_line[c];
    for (int k = 0; k < 3; k++) begin
      window[3*k]   = window[3*k+1];
      window[3*k+1] = window[3*k+2];
    end
    window[2] = top;
    window[5] = mid;
    window[8] = pix;
    upper_line[c]  = mid;
    middle_line[c] = pix;
    if (r >= 2 && c >= 2) begin
      peak = '0;
      foreach (window[k]) if (window[k] > peak) peak = window[k];
      pending_gradients.push_back('{grad: PIX_W'(peak - window[4]),
                                    row:  ROW_W'(r - 1),
                                    col:  COL_W'(c - 1),
                                    last: (r == h - 1 && c == w - 1)});
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end
  endfunction

  function automatic int unsigned pixels_left_in_frame();
    int unsigned w, h, r, c;
    w = frame_width();
    h = frame_height();
    r = row_cnt;
    c = col_cnt;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    return (r == 0 && c == 0) ? 0 : (h - r) * w - c;
  endfunction

  function automatic logic [PIX_W-1:0] draw_pixel(input tone_t tone);
    case (tone)
      TONE_BINARY: return $urandom_range(0, 1) ? {PIX_W{1'b1}} : '0;
      TONE_BAND:   return PIX_W'($urandom_range(96, 103));
      default:     return PIX_W'($urandom);
    endcase
  endfunction

  function automatic void queue_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] value);
    reg_writes_q.push_back('{idx: idx, value: value});
  endfunction

  task automatic write_regs();
    reg_write_t wr;
    while (reg_writes_q.size() != 0) begin
      wr = reg_writes_q.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= wr.idx;
      cfg_data_i  <= wr.value;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (wr.idx)
        CFG_IDX_WIDTH:  width_reg  = wr.value[WIDTH_W-1:0];
        CFG_IDX_HEIGHT: height_reg = wr.value[HEIGHT_W-1:0];
        default: ;
      endcase
      n_reg_writes++;
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    if (src_gaps_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_value_i <= pix;
    do @(posedge clk_i); while (in_stall_o);
    predict_gradient(pix);
    n_pixels++;
  endtask

  task automatic send_pixels(input int unsigned n, input tone_t tone);
    repeat (n) send_pixel(draw_pixel(tone));
  endtask

  // drain all results, then let in-flight border pixels clear the pipeline
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_gradients.size() != 0) @(posedge clk_i);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic test_reset_geometry();
    send_pixels(640 + 8, TONE_FULL);
    settle();
  endtask

  task automatic test_border_extremes();
    queue_reg(CFG_IDX_WIDTH, CFG_DAT_W'(3));
    queue_reg(CFG_IDX_HEIGHT, CFG_DAT_W'(3));
    write_regs();
    send_pixels(pixels_left_in_frame(), TONE_FULL);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'h00 : 8'hFF);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'hFF : 8'h00);
    settle();
  endtask

  task automatic test_size_clamping();
    queue_reg(CFG_IDX_WIDTH, '0);
    queue_reg(CFG_IDX_HEIGHT, '0);
    write_regs();
    send_pixels(9, TONE_FULL);
    settle();
    queue_reg(CFG_IDX_WIDTH, CFG_DAT_W'(2));
    queue_reg(CFG_IDX_HEIGHT, CFG_DAT_W'(2));
    write_regs();
    send_pixels(9, TONE_BINARY);
    settle();
    // upper data bits beyond the width register drop away
    queue_reg(CFG_IDX_WIDTH, 16'h2005);
    queue_reg(CFG_IDX_HEIGHT, CFG_DAT_W'(4));
    write_regs();
    send_pixels(20, TONE_FULL);
    settle();
  endtask

  task automatic test_ignored_index();
    queue_reg(CFG_IDX_RSVD2, 16'hFFFF);
    queue_reg(CFG_IDX_RSVD3, CFG_DAT_W'($urandom));
    write_regs();
    send_pixels(20, TONE_BAND);
    settle();
  endtask

  task automatic test_extreme_sizes();
    queue_reg(CFG_IDX_WIDTH, CFG_DAT_W'(3));
    queue_reg(CFG_IDX_HEIGHT, 16'hFFFF);
    write_regs();
    send_pixels(60, TONE_FULL);
    settle();
    queue_reg(CFG_IDX_WIDTH, 16'hFFFF);
    queue_reg(CFG_IDX_HEIGHT, CFG_DAT_W'(1));
    write_regs();
    send_pixels(40, TONE_FULL);
    settle();
  endtask

  task automatic test_mid_frame_resize();
    queue_reg(CFG_IDX_WIDTH, CFG_DAT_W'(10));
    queue_reg(CFG_IDX_HEIGHT, CFG_DAT_W'(8));
    write_regs();
    send_pixels(35, TONE_FULL);
    settle();
    queue_reg(CFG_IDX_WIDTH, CFG_DAT_W'(4));
    write_regs();
    send_pixels(10, TONE_FULL);
    settle();
    queue_reg(CFG_IDX_HEIGHT, CFG_DAT_W'(3));
    write_regs();
    send_pixels(30, TONE_FULL);
    settle();
  endtask

  task automatic test_random_frames();
    int unsigned start, w, h, n, left;
    tone_t tone;
    start = n_pixels;
    while (n_pixels - start < RANDOM_ITEMS) begin
      src_gaps_en   = ($urandom_range(0, 3) != 0);
      sink_stall_en = ($urandom_range(0, 3) != 0);
      tone = tone_t'($urandom_range(0, 2));
      left = pixels_left_in_frame();
      if (left != 0 && left <= 600 && $urandom_range(0, 3) != 0) begin
        send_pixels(left, tone);
        settle();
      end
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 200) : $urandom_range(3, 24);
      h = $urandom_range(3, 12);
      queue_reg(CFG_IDX_WIDTH, CFG_DAT_W'(w));
      queue_reg(CFG_IDX_HEIGHT, CFG_DAT_W'(h));
      write_regs();
      n = w * h * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, w * h);
      send_pixels(n, tone);
      settle();
    end
  endtask

  task automatic test_no_idle_tail();
    src_gaps_en   = 1'b0;
    sink_stall_en = 1'b0;
    queue_reg(CFG_IDX_WIDTH, CFG_DAT_W'(9));
    queue_reg(CFG_IDX_HEIGHT, CFG_DAT_W'(5));
    write_regs();
    send_pixels(pixels_left_in_frame() + 2 * 9 * 5, TONE_FULL);
    settle();
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (sink_stall_en && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 16);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_res = '{grad: gradient_value_o, row: center_row_o,
                  col: center_col_o, last: frame_last_o};
      n_results++;
      if (frame_last_o) n_frame_ends++;
      if (pending_gradients.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t unexpected item: grad=%0d row=%0d col=%0d last=%0b", $realtime,
                   got_res.grad, got_res.row, got_res.col, got_res.last);
      end else begin
        exp_res = pending_gradients.pop_front();
        if (got_res.grad !== exp_res.grad || got_res.row !== exp_res.row ||
            got_res.col !== exp_res.col || got_res.last !== exp_res.last) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t mismatch: exp %0d %0d %0d %0b, got %0d %0d %0d %0b",
                     $realtime, exp_res.grad, exp_res.row, exp_res.col, exp_res.last,
                     got_res.grad, got_res.row, got_res.col, got_res.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d cycles with no item moving, %0d results outstanding",
               quiet_cycles, pending_gradients.size());
      $display("** morph_gradient_3x3: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (upper_line[i]) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    foreach (window[i]) window[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_geometry();
    test_border_extremes();
    test_size_clamping();
    test_ignored_index();
    test_extreme_sizes();
    test_mid_frame_resize();
    test_random_frames();
    test_no_idle_tail();

    $display("covered %0d pixels and %0d register writes, frames from 3x3 to 4096 wide",
             n_pixels, n_reg_writes);
    $display("checked %0d gradient items, %0d frame ends, %0d mismatches",
             n_results, n_frame_ends, n_errors);
    if (n_errors == 0) begin
      $display("** morph_gradient_3x3: PASSED **");
    end else begin
      $display("** morph_gradient_3x3: FAILED **");
    end
    $finish;
  end

endmodule : tb_top
